@@ hw/rtl/scl_pkg.sv @@
package scl_pkg;

	localparam int IN_DATA_W   = 8;
	localparam int OUT_VALUE_W = 16;
	localparam int OUT_DATA_W  = 24;
	localparam int COUNT_W     = 3;
	localparam int KW_COUNT    = 5;
	localparam int KW_SLOTS    = 8;

	localparam logic [IN_DATA_W-1:0] CHAR_DOT   = 8'h2E;
	localparam logic [IN_DATA_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [IN_DATA_W-1:0] CHAR_NINE  = 8'h39;
	localparam logic [IN_DATA_W-1:0] CHAR_LOW_A = 8'h61;
	localparam logic [IN_DATA_W-1:0] CHAR_LOW_Z = 8'h7A;
	localparam logic [IN_DATA_W-1:0] CASE_DIFF  = 8'h20;
	localparam logic [COUNT_W-1:0]   COUNT_MAX  = 3'd7;

	typedef enum logic [2:0] {
		CODE_EMPTY   = 3'd0,
		CODE_INVALID = 3'd1,
		CODE_F       = 3'd2,
		CODE_B       = 3'd3,
		CODE_ON      = 3'd4,
		CODE_OFF     = 3'd5,
		CODE_RESET   = 3'd6,
		CODE_NUMBER  = 3'd7
	} line_code_t;

	typedef struct packed {
		logic [OUT_VALUE_W-1:0] value;
		line_code_t             code;
	} line_res_t;

	localparam int OUT_RES_W = $bits(line_res_t);

	localparam logic [IN_DATA_W-1:0] KW_TEXT [KW_COUNT][KW_SLOTS] = '{
		'{"F", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"B", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"O", "N", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"O", "F", "F", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"R", "E", "S", "E", "T", 8'h00, 8'h00, 8'h00}
	};

	localparam logic [COUNT_W-1:0] KW_LEN [KW_COUNT] = '{3'd1, 3'd1, 3'd2, 3'd3, 3'd5};

	localparam line_code_t KW_CODE [KW_COUNT] = '{CODE_F, CODE_B, CODE_ON, CODE_OFF, CODE_RESET};

	function automatic logic is_kw_letter(input logic [IN_DATA_W-1:0] up);
		return up inside {"O", "N", "F", "B", "R", "E", "S", "T"};
	endfunction

endpackage

@@ hw/rtl/scl_line.sv @@
module scl_line #(
	parameter int VALUE_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic [scl_pkg::IN_DATA_W-1:0] ch,
	output scl_pkg::line_res_t            res
);
	import scl_pkg::*;

	localparam int WX = VALUE_WIDTH + 4;

	logic [COUNT_W-1:0]     count_q, count_n;
	logic                   digits_first_q, digits_first_n;
	logic                   bad_q, bad_n;
	logic [KW_COUNT-1:0]    cand_q, cand_n;
	logic [VALUE_WIDTH-1:0] acc_q, acc_n;

	logic                   is_dot, is_digit;
	logic [IN_DATA_W-1:0]   up;
	logic [WX-1:0]          acc_x, prod;
	logic [VALUE_WIDTH-1:0] acc_dig;
	logic [VALUE_WIDTH+OUT_VALUE_W-1:0] acc_ext;

	assign is_dot   = (ch == CHAR_DOT);
	assign is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
	assign up       = ((ch >= CHAR_LOW_A) && (ch <= CHAR_LOW_Z)) ? (ch - CASE_DIFF) : ch;

	assign acc_x   = WX'(acc_q);
	assign prod    = (acc_x << 3) + (acc_x << 1) + WX'(ch[3:0]);
	assign acc_dig = (|prod[WX-1:VALUE_WIDTH]) ? '1 : prod[VALUE_WIDTH-1:0];
	assign acc_ext = {{OUT_VALUE_W{1'b0}}, acc_q};

	always_comb begin
		count_n        = count_q;
		digits_first_n = digits_first_q;
		bad_n          = bad_q;
		cand_n         = cand_q;
		acc_n          = acc_q;
		if (is_dot) begin
			count_n        = '0;
			digits_first_n = 1'b0;
			bad_n          = 1'b0;
			cand_n         = '1;
			acc_n          = '0;
		end else begin
			if (is_digit) begin
				if (count_q == '0) begin
					digits_first_n = 1'b1;
				end else if (!digits_first_q) begin
					bad_n = 1'b1;
				end
				if ((count_q == '0) || digits_first_q) begin
					acc_n = acc_dig;
				end
				cand_n = '0;
			end else begin
				if (!is_kw_letter(up) || digits_first_q) begin
					bad_n = 1'b1;
				end
				for (int k = 0; k < KW_COUNT; k++) begin
					if ((count_q >= KW_LEN[k]) || (KW_TEXT[k][count_q] != up)) begin
						cand_n[k] = 1'b0;
					end
				end
			end
			if (count_q != COUNT_MAX) begin
				count_n = count_q + 1'b1;
			end
		end
	end

	always_comb begin
		res.code  = CODE_INVALID;
		res.value = '0;
		if (count_q == '0) begin
			res.code = CODE_EMPTY;
		end else if (!bad_q) begin
			if (digits_first_q) begin
				res.code  = CODE_NUMBER;
				res.value = acc_ext[OUT_VALUE_W-1:0];
			end else begin
				for (int k = 0; k < KW_COUNT; k++) begin
					if (cand_q[k] && (count_q == KW_LEN[k])) begin
						res.code = KW_CODE[k];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			digits_first_q <= 1'b0;
			bad_q          <= 1'b0;
			cand_q         <= '1;
			acc_q          <= '0;
		end else if (go) begin
			count_q        <= count_n;
			digits_first_q <= digits_first_n;
			bad_q          <= bad_n;
			cand_q         <= cand_n;
			acc_q          <= acc_n;
		end
	end

endmodule

@@ hw/rtl/scl_outreg.sv @@
module scl_outreg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  scl_pkg::line_res_t res,
	input  logic               ready,
	output logic               valid,
	output logic               free,
	output scl_pkg::line_res_t res_q
);
	import scl_pkg::*;

	logic valid_q;

	assign valid = valid_q;
	assign free  = !valid_q || ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

@@ hw/rtl/serial_command_line_recognizer.sv @@
// Serial command line recognizer.
// Input stream: one received character per request on s_axis. A '.' ends
// the line; every other character only updates the line state.
// Output stream: one request on m_axis per '.', carrying the line code
// (empty, invalid, F, B, ON, OFF, RESET, number) and the decimal value of
// a digit line, saturated at 2^VALUE_WIDTH - 1 (low 16 bits shown).
// Path: an accepted '.' is registered in the input register; once the output
// register is free, the line result is loaded there and shown on m_axis.
// Throughput: one character per cycle unless a '.' stalls; the line update
// and keyword match sit in one stage between input and output register.
// Stall: while the output register is full and m_axis_tready is low, a '.'
// holds in the input register and s_axis_tready drops; characters that are
// not '.' keep flowing until the next '.' reaches the input register.
// Reset: clears the line state (empty line, all keywords open) and both
// valid flags; no result is pending after reset.
module serial_command_line_recognizer #(
	parameter int VALUE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [scl_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [7:0] rx_char
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [scl_pkg::OUT_DATA_W-1:0] m_axis_tdata   // [2:0] line_code, [18:3] line_value
);
	import scl_pkg::*;

	logic [IN_DATA_W-1:0] rx_s1;
	logic                 rx_valid_s1;
	logic                 is_dot_s1;
	logic                 go;
	logic                 out_free;
	line_res_t            res;
	line_res_t            out_res_q;

	assign is_dot_s1     = (rx_s1 == CHAR_DOT);
	assign go            = rx_valid_s1 && (!is_dot_s1 || out_free);
	assign s_axis_tready = !rx_valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			rx_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			rx_s1 <= s_axis_tdata;
		end
	end

	scl_line #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_line (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (go),
		.ch    (rx_s1),
		.res   (res)
	);

	scl_outreg u_out (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (go && is_dot_s1),
		.res   (res),
		.ready (m_axis_tready),
		.valid (m_axis_tvalid),
		.free  (out_free),
		.res_q (out_res_q)
	);

	assign m_axis_tdata = {{(OUT_DATA_W - OUT_RES_W){1'b0}}, out_res_q};

endmodule

@@ hw/rtl/scl_checker.sv @@
module scl_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic [scl_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [scl_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import scl_pkg::*;

	logic [2:0]             code;
	logic [OUT_VALUE_W-1:0] value;

	assign code  = m_axis_tdata[2:0];
	assign value = m_axis_tdata[OUT_RES_W-1:3];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output request dropped or changed while stalled");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:OUT_RES_W] == '0)
		else $error("padding bits of output not zero");

	a_value_number: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && code != CODE_NUMBER |-> value == '0)
		else $error("nonzero value on a line that is not a number");

	a_result_after_dot: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(m_axis_tvalid) && !$past(s_axis_tready) ||
			$past(s_axis_tvalid && s_axis_tready && s_axis_tdata == CHAR_DOT, 2) ||
			!$past(s_axis_tready, 2))
		else $error("result appeared without a line end");

endmodule

bind serial_command_line_recognizer scl_checker u_scl_checker (.*);
